@@ design/assert_macros.svh @@
// Assertion macros shared by the loader RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ design/hrbl_pkg.sv @@
// Package: shared types and constants of the hex record bank loader
`default_nettype none

package hrbl_pkg;

   localparam int CHAR_W      = 8;
   localparam int ADDR_W      = 21;
   localparam int KIND_W      = 2;
   localparam int BANK_CNT_W  = 7;
   localparam int NIB_W       = 4;

   localparam logic [BANK_CNT_W-1:0] MIN_BANKS   = 7'd2;
   localparam logic [BANK_CNT_W-1:0] MAX_BANKS   = 7'd64;
   localparam logic [BANK_CNT_W-1:0] BANK_EXTRA  = 7'd5;
   localparam logic [7:0]            BANKS_LIMIT = 8'd255;

   localparam logic [15:0] BANK_START = 16'hC000;
   localparam logic [15:0] BANK_SIZE  = 16'h4000;
   localparam int          BANK_SHIFT = 14;

   // Image size is a multiple of 16 KiB, so the fold works on the upper bits only
   localparam int FOLD_W = 32 - BANK_SHIFT;
   localparam int MOD_W  = BANK_CNT_W;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] DIGIT_LO   = 8'h30;
   localparam logic [CHAR_W-1:0] DIGIT_HI   = 8'h39;
   localparam logic [CHAR_W-1:0] UPPER_LO   = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_HI   = 8'h46;
   localparam logic [CHAR_W-1:0] UPPER_BASE = 8'h37;
   localparam logic [CHAR_W-1:0] LOWER_LO   = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_HI   = 8'h66;
   localparam logic [CHAR_W-1:0] LOWER_BASE = 8'h57;

   localparam logic [7:0] REC_DATA      = 8'h00;
   localparam logic [7:0] REC_EOF       = 8'h01;
   localparam logic [7:0] REC_EXT_SEG   = 8'h02;
   localparam logic [7:0] REC_START_SEG = 8'h03;
   localparam logic [7:0] REC_EXT_LIN   = 8'h04;
   localparam logic [7:0] REC_START_LIN = 8'h05;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE,
      KIND_SKIP,
      KIND_EMPTY,
      KIND_UNKNOWN
   } result_kind_type;

   typedef enum logic [1:0] {
      TOK_COLON,
      TOK_HEX,
      TOK_OTHER
   } token_class_type;

   typedef struct packed {
      token_class_type  cls;
      logic [NIB_W-1:0] nib;
   } token_type;

   typedef struct packed {
      logic              start;
      logic [FOLD_W-1:0] dividend;
      logic [MOD_W-1:0]  divisor;
   } fold_req_type;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] remainder;
   } fold_rsp_type;

endpackage

`default_nettype wire

@@ design/hrbl_req_if.sv @@
// Interface: character input channel
`default_nettype none

interface hrbl_req_if;
   import hrbl_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

@@ design/hrbl_rsp_if.sv @@
// Interface: result channel carrying memory writes and record flags
`default_nettype none

interface hrbl_rsp_if;
   import hrbl_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [ADDR_W-1:0] write_address;
   logic [CHAR_W-1:0] write_data;

   modport source (output valid, output result_kind, output write_address,
                   output write_data, input ready);
   modport sink (input valid, input result_kind, input write_address,
                 input write_data, output ready);
endinterface

`default_nettype wire

@@ design/hrbl_front.sv @@
// Front stage: accepts characters and classifies them into tokens
`default_nettype none

module hrbl_front (
   input  wire logic          clock,
   input  wire logic          reset,
   hrbl_req_if.sink           req_chan,
   output logic               tok_valid,
   input  wire logic          tok_ready,
   output hrbl_pkg::token_type tok
);
   import hrbl_pkg::*;

   logic      tok_valid_ff, tok_valid_in;
   token_type tok_ff, tok_in;
   logic      take;

   assign req_chan.ready = !tok_valid_ff || tok_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign tok_valid      = tok_valid_ff;
   assign tok            = tok_ff;

   always_comb begin
      tok_in.cls = TOK_OTHER;
      tok_in.nib = '0;
      case (req_chan.char_code) inside
         CHAR_COLON: begin
            tok_in.cls = TOK_COLON;
         end
         [DIGIT_LO:DIGIT_HI]: begin
            tok_in.cls = TOK_HEX;
            tok_in.nib = NIB_W'(req_chan.char_code - DIGIT_LO);
         end
         [UPPER_LO:UPPER_HI]: begin
            tok_in.cls = TOK_HEX;
            tok_in.nib = NIB_W'(req_chan.char_code - UPPER_BASE);
         end
         [LOWER_LO:LOWER_HI]: begin
            tok_in.cls = TOK_HEX;
            tok_in.nib = NIB_W'(req_chan.char_code - LOWER_BASE);
         end
         default: begin
            tok_in.cls = TOK_OTHER;
         end
      endcase
      tok_valid_in = req_chan.ready ? req_chan.valid : tok_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
      if (take) begin
         tok_ff <= tok_in;
      end
   end

endmodule

`default_nettype wire

@@ design/hrbl_queue.sv @@
// Token queue between the front and back stages
`default_nettype none
`include "assert_macros.svh"

module hrbl_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire hrbl_pkg::token_type  push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output hrbl_pkg::token_type       pop_data
);
   import hrbl_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   token_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;
   logic [PTR_W-1:0] ptr_gap;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign ptr_gap    = wr_ptr_ff - rd_ptr_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_queue_count_bound, count_ff <= FULL_COUNT, "queue count above depth")
   `ASSERT_ALWAYS(a_queue_ptr_gap, ptr_gap == PTR_W'(count_ff), "queue pointers disagree with count")

endmodule

`default_nettype wire

@@ design/hrbl_fold.sv @@
// Serial remainder unit: one quotient bit per cycle, folds addresses into the image
`default_nettype none
`include "assert_macros.svh"

module hrbl_fold (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hrbl_pkg::fold_req_type fold_req,
   output hrbl_pkg::fold_rsp_type      fold_rsp
);
   import hrbl_pkg::*;

   localparam int STEP_W = $clog2(FOLD_W + 1);

   logic [FOLD_W-1:0] num_ff, num_in;
   logic [MOD_W-1:0]  div_ff, div_in;
   logic [MOD_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MOD_W:0]    trial;
   logic [MOD_W:0]    diff;
   logic              fits;

   assign fold_rsp.done      = done_ff;
   assign fold_rsp.remainder = rem_ff;

   always_comb begin
      trial   = {rem_ff, num_ff[FOLD_W-1]};
      diff    = trial - {1'b0, div_ff};
      fits    = trial >= {1'b0, div_ff};
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (fold_req.start) begin
         num_in  = fold_req.dividend;
         div_in  = fold_req.divisor;
         rem_in  = '0;
         step_in = STEP_W'(FOLD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
         num_in  = {num_ff[FOLD_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   `ASSERT_IMPLY(a_fold_rem_below, done_ff, rem_ff < div_ff, "remainder not below divisor")
   `ASSERT_IMPLY(a_fold_busy_steps, busy_ff, step_ff != '0, "fold busy with no steps left")

endmodule

`default_nettype wire

@@ design/hrbl_back.sv @@
// Back stage: record parser, bank counter, address forming and result register
`default_nettype none
`include "assert_macros.svh"

module hrbl_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_en,
   input  wire logic [hrbl_pkg::BANK_CNT_W-1:0]      csr_write_data,
   input  wire logic                                 tok_valid,
   output logic                                      tok_ready,
   input  wire hrbl_pkg::token_type                  tok,
   output hrbl_pkg::fold_req_type                    fold_req,
   input  wire hrbl_pkg::fold_rsp_type               fold_rsp,
   hrbl_rsp_if.source                                rsp_chan
);
   import hrbl_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_COUNT,
      PH_ADDR,
      PH_TYPE,
      PH_DATA,
      PH_EXT,
      PH_TAIL,
      PH_PLACE,
      PH_FOLD,
      PH_CHECK
   } phase_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_LINEAR,
      MODE_SEGMENT
   } mode_type;

   phase_type         phase_ff, phase_in;
   mode_type          mode_ff, mode_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [3:0]        hi_ff, hi_in;
   logic [7:0]        len_ff, len_in;
   logic [15:0]       off_ff, off_in;
   logic [7:0]        kind_ff, kind_in;
   logic [7:0]        left_ff, left_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [15:0]       seg_ff, seg_in;
   logic [15:0]       upper_ff, upper_in;
   logic [7:0]        banks_ff, banks_in;
   logic [22:0]       addr_ff, addr_in;
   logic [23:0]       phys_ff, phys_in;
   logic [BANK_SHIFT-1:0] low_ff, low_in;
   logic [BANK_CNT_W-1:0] bank_cnt_ff, bank_cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   result_kind_type   rsp_kind_ff, rsp_kind_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [CHAR_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  emit;
   logic                  out_free;
   logic                  busy_phase;
   logic                  take;
   logic [7:0]            kind_next;
   logic [15:0]           off_next;
   logic [7:0]            banks_new;
   logic [22:0]           addr_calc;
   logic [31:0]           linear_sum;
   logic [BANK_CNT_W-1:0] bank_eff;
   logic [MOD_W-1:0]      img_banks;
   logic [ADDR_W-1:0]     img_size;
   logic [24:0]           rec_end;
   mode_type              want_mode;
   mode_type              mode_eff;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign busy_phase = phase_ff == PH_PLACE || phase_ff == PH_FOLD || phase_ff == PH_CHECK;
   assign tok_ready  = out_free && !busy_phase;
   assign take       = tok_valid && tok_ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_kind   = rsp_kind_ff;
   assign rsp_chan.write_address = rsp_addr_ff;
   assign rsp_chan.write_data    = rsp_data_ff;

   always_comb begin
      bank_eff = bank_cnt_ff;
      if (bank_cnt_ff < MIN_BANKS) begin
         bank_eff = MIN_BANKS;
      end else if (bank_cnt_ff > MAX_BANKS) begin
         bank_eff = MAX_BANKS;
      end
      img_banks = bank_eff + BANK_EXTRA;
      img_size  = {img_banks, {BANK_SHIFT{1'b0}}};

      kind_next = {kind_ff[3:0], tok.nib};
      off_next  = {off_ff[11:0], tok.nib};

      // advance the bank counter on a record placed at the bank window start
      banks_new = banks_ff;
      if (off_ff == BANK_START && banks_ff != BANKS_LIMIT) begin
         banks_new = banks_ff + 8'd1;
      end
      if (off_ff < BANK_START) begin
         addr_calc = {7'd0, off_ff};
      end else if (banks_new == 8'd0) begin
         addr_calc = {7'd0, off_ff} - {7'd0, BANK_SIZE};
      end else begin
         addr_calc = {7'd0, off_ff} + {1'b0, banks_new - 8'd1, {BANK_SHIFT{1'b0}}};
      end

      linear_sum = {upper_ff, 16'd0} + {9'd0, addr_ff};
      rec_end    = {1'b0, phys_ff} + {17'd0, len_ff};

      want_mode = (kind_next == REC_EXT_SEG) ? MODE_SEGMENT : MODE_LINEAR;
      mode_eff  = (mode_ff == MODE_NONE) ? want_mode : mode_ff;

      phase_in    = phase_ff;
      mode_in     = mode_ff;
      cnt_in      = cnt_ff;
      hi_in       = hi_ff;
      len_in      = len_ff;
      off_in      = off_ff;
      kind_in     = kind_ff;
      left_in     = left_ff;
      wp_in       = wp_ff;
      seg_in      = seg_ff;
      upper_in    = upper_ff;
      banks_in    = banks_ff;
      addr_in     = addr_ff;
      phys_in     = phys_ff;
      low_in      = low_ff;
      bank_cnt_in = csr_write_en ? csr_write_data : bank_cnt_ff;

      fold_req.start    = 1'b0;
      fold_req.dividend = linear_sum[31:BANK_SHIFT];
      fold_req.divisor  = img_banks;

      emit        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_data_in = rsp_data_ff;

      case (phase_ff)
         PH_PLACE: begin
            if (mode_ff == MODE_SEGMENT) begin
               phys_in  = {4'd0, seg_ff, 4'd0} + {1'b0, addr_ff};
               phase_in = PH_CHECK;
            end else begin
               fold_req.start = 1'b1;
               low_in         = linear_sum[BANK_SHIFT-1:0];
               phase_in       = PH_FOLD;
            end
         end
         PH_FOLD: begin
            if (fold_rsp.done) begin
               phys_in  = 24'({fold_rsp.remainder, low_ff});
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            if (rec_end > {4'd0, img_size}) begin
               emit        = 1'b1;
               rsp_kind_in = KIND_SKIP;
               rsp_addr_in = phys_ff[ADDR_W-1:0];
               rsp_data_in = '0;
               phase_in    = PH_TAIL;
            end else begin
               wp_in    = phys_ff[ADDR_W-1:0];
               left_in  = len_ff;
               cnt_in   = '0;
               phase_in = PH_DATA;
            end
         end
         default: begin
            if (take) begin
               if (tok.cls == TOK_COLON) begin
                  phase_in = PH_COUNT;
                  cnt_in   = '0;
                  len_in   = '0;
                  off_in   = '0;
                  kind_in  = '0;
               end else if (phase_ff == PH_IDLE) begin
                  phase_in = PH_IDLE;
               end else if (tok.cls != TOK_HEX) begin
                  phase_in = PH_IDLE;
               end else begin
                  case (phase_ff)
                     PH_COUNT: begin
                        len_in = {len_ff[3:0], tok.nib};
                        cnt_in = cnt_ff + 2'd1;
                        if (cnt_ff == 2'd1) begin
                           cnt_in   = '0;
                           phase_in = PH_ADDR;
                        end
                     end
                     PH_ADDR: begin
                        off_in = off_next;
                        cnt_in = cnt_ff + 2'd1;
                        if (cnt_ff == 2'd3) begin
                           cnt_in   = '0;
                           phase_in = PH_TYPE;
                        end
                     end
                     PH_TYPE: begin
                        kind_in = kind_next;
                        cnt_in  = cnt_ff + 2'd1;
                        if (cnt_ff == 2'd1) begin
                           cnt_in = '0;
                           case (kind_next)
                              REC_DATA: begin
                                 if (len_ff == 8'd0) begin
                                    emit        = 1'b1;
                                    rsp_kind_in = KIND_EMPTY;
                                    rsp_addr_in = ADDR_W'(off_ff);
                                    rsp_data_in = '0;
                                    phase_in    = PH_TAIL;
                                 end else begin
                                    banks_in = banks_new;
                                    addr_in  = addr_calc;
                                    phase_in = PH_PLACE;
                                 end
                              end
                              REC_EXT_SEG, REC_EXT_LIN: begin
                                 mode_in = mode_eff;
                                 if (mode_eff == want_mode) begin
                                    phase_in = PH_EXT;
                                    off_in   = '0;
                                 end else begin
                                    phase_in = PH_TAIL;
                                 end
                              end
                              REC_EOF, REC_START_SEG, REC_START_LIN: begin
                                 phase_in = PH_TAIL;
                              end
                              default: begin
                                 emit        = 1'b1;
                                 rsp_kind_in = KIND_UNKNOWN;
                                 rsp_addr_in = ADDR_W'(off_ff);
                                 rsp_data_in = '0;
                                 phase_in    = PH_TAIL;
                              end
                           endcase
                        end
                     end
                     PH_DATA: begin
                        if (cnt_ff == 2'd0) begin
                           hi_in  = tok.nib;
                           cnt_in = 2'd1;
                        end else begin
                           cnt_in      = '0;
                           emit        = 1'b1;
                           rsp_kind_in = KIND_WRITE;
                           rsp_addr_in = wp_ff;
                           rsp_data_in = {hi_ff, tok.nib};
                           wp_in       = wp_ff + 1'b1;
                           left_in     = left_ff - 8'd1;
                           if (left_ff == 8'd1) begin
                              phase_in = PH_TAIL;
                           end
                        end
                     end
                     PH_EXT: begin
                        off_in = off_next;
                        cnt_in = cnt_ff + 2'd1;
                        if (cnt_ff == 2'd3) begin
                           cnt_in = '0;
                           if (kind_ff == REC_EXT_SEG) begin
                              seg_in = off_next;
                           end else begin
                              upper_in = off_next;
                           end
                           phase_in = PH_TAIL;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         mode_ff      <= MODE_NONE;
         cnt_ff       <= '0;
         seg_ff       <= '0;
         upper_ff     <= '0;
         banks_ff     <= '0;
         bank_cnt_ff  <= MIN_BANKS;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         seg_ff       <= seg_in;
         upper_ff     <= upper_in;
         banks_ff     <= banks_in;
         bank_cnt_ff  <= bank_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hi_ff       <= hi_in;
      len_ff      <= len_in;
      off_ff      <= off_in;
      kind_ff     <= kind_in;
      left_ff     <= left_in;
      wp_ff       <= wp_in;
      addr_ff     <= addr_in;
      phys_ff     <= phys_in;
      low_ff      <= low_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_IMPLY(a_back_no_overrun, emit, out_free, "result produced over an untaken result")
   `ASSERT_IMPLY(a_back_data_left, phase_ff == PH_DATA, left_ff != 8'd0, "data phase with no bytes left")

endmodule

`default_nettype wire

@@ design/hex_record_bank_loader_top.sv @@
// Top level: hex record bank loader, front classifier, token queue, fold unit and parser
//
// Takes one ASCII character of Intel HEX text per req_chan transfer and returns
// memory writes and record flags on rsp_chan, at most one result per character.
// The front stage accepts a character every cycle into a 4-entry token queue with room;
// the parser drains one token per cycle while its result register is free (see below).
// Completing the type field of a non-empty data record passes through PH_PLACE and
// PH_CHECK in segmented mode, and through PH_PLACE, PH_FOLD and PH_CHECK otherwise;
// in PH_FOLD the serial remainder unit folds linear addresses into the image size.
// The parser takes no tokens meanwhile. A record of n data bytes is 2n + 11 characters.
// bank_count is to be written through csr_write_en/csr_write_data while the block is
// idle, unenforced by the block; it is clamped to 2..64; no clearing pass follows reset.
`default_nettype none

module hex_record_bank_loader_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [hrbl_pkg::BANK_CNT_W-1:0] csr_write_data,
   hrbl_req_if.sink                             req_chan,
   hrbl_rsp_if.source                           rsp_chan
);
   import hrbl_pkg::*;

   logic         front_valid;
   logic         front_ready;
   token_type    front_tok;
   logic         queue_valid;
   logic         queue_ready;
   token_type    queue_tok;
   fold_req_type fold_req;
   fold_rsp_type fold_rsp;

   hrbl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .tok_valid (front_valid),
      .tok_ready (front_ready),
      .tok       (front_tok)
   );

   hrbl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_tok),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_tok)
   );

   hrbl_fold u_fold (
      .clock    (clock),
      .reset    (reset),
      .fold_req (fold_req),
      .fold_rsp (fold_rsp)
   );

   hrbl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .tok_valid      (queue_valid),
      .tok_ready      (queue_ready),
      .tok            (queue_tok),
      .fold_req       (fold_req),
      .fold_rsp       (fold_rsp),
      .rsp_chan       (rsp_chan)
   );

endmodule

`default_nettype wire

@@ test/tb_hex_record_bank_loader_top.sv @@
// Testbench: hex record bank loader driven with directed and random HEX text, checked per result
`default_nettype none

module tb_hex_record_bank_loader_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hrbl_pkg::*;

   localparam int HOLD_CYCLES = 64;
   localparam int END_CYCLES  = 80;
   localparam int STALL_LIMIT = 4000;

   typedef enum logic [2:0] {
      ST_IDLE, ST_COUNT, ST_OFFSET, ST_TYPE, ST_DATA, ST_EXT, ST_TAIL
   } parse_state_type;

   typedef enum logic [1:0] {MODE_NONE, MODE_LINEAR, MODE_SEGMENT} addr_mode_type;

   typedef struct packed {
      result_kind_type   kind;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } loader_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [BANK_CNT_W-1:0] csr_write_data;

   hrbl_req_if req_bus ();
   hrbl_rsp_if rsp_bus ();

   hex_record_bank_loader_top u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus)
   );

   // parser model state
   parse_state_type       pstate       = ST_IDLE;
   int unsigned           nib_count    = 0;
   logic [3:0]            high_nib     = '0;
   logic [7:0]            rec_len      = '0;
   logic [15:0]           rec_offset   = '0;
   logic [7:0]            rec_type     = '0;
   logic [7:0]            bytes_left   = '0;
   logic [ADDR_W-1:0]     write_ptr    = '0;
   logic [15:0]           seg_base     = '0;
   logic [15:0]           upper_base   = '0;
   addr_mode_type         addr_mode    = MODE_NONE;
   logic [7:0]            banks_seen   = '0;
   logic [BANK_CNT_W-1:0] bank_setting = MIN_BANKS;

   loader_result_type pending_results[$];
   int                fail_count    = 0;
   int                chars_sent    = 0;
   int                idle_cycles   = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= DIGIT_LO && c <= DIGIT_HI) return int'(c - DIGIT_LO);
      if (c >= UPPER_LO && c <= UPPER_HI) return int'(c - UPPER_BASE);
      if (c >= LOWER_LO && c <= LOWER_HI) return int'(c - LOWER_BASE);
      return -1;
   endfunction

   function automatic logic [31:0] image_bytes();
      int unsigned b;
      b = bank_setting;
      if (b < MIN_BANKS) b = MIN_BANKS;
      if (b > MAX_BANKS) b = MAX_BANKS;
      return 32'((b + BANK_EXTRA) << BANK_SHIFT);
   endfunction

   function automatic bit finish_type(output loader_result_type res);
      logic [31:0]   img;
      logic [31:0]   addr;
      logic [31:0]   phys;
      logic [32:0]   span_end;
      addr_mode_type want;
      res = '0;
      img = image_bytes();
      case (rec_type)
         REC_DATA: begin
            if (rec_len == 0) begin
               res.kind = KIND_EMPTY;
               res.addr = ADDR_W'(rec_offset);
               pstate = ST_TAIL;
               return 1'b1;
            end
            if (rec_offset == BANK_START && banks_seen != BANKS_LIMIT) banks_seen++;
            addr = 32'(rec_offset);
            if (rec_offset >= BANK_START)
               addr = addr + (32'(banks_seen) - 32'd1) * 32'(BANK_SIZE);
            if (addr_mode == MODE_SEGMENT) begin
               phys = (32'(seg_base) << 4) + addr;
            end else begin
               phys = ((32'(upper_base) << 16) + addr) % img;
            end
            span_end = 33'(phys) + 33'(rec_len);
            if (span_end > 33'(img)) begin
               res.kind = KIND_SKIP;
               res.addr = phys[ADDR_W-1:0];
               pstate = ST_TAIL;
               return 1'b1;
            end
            write_ptr = phys[ADDR_W-1:0];
            bytes_left = rec_len;
            pstate = ST_DATA;
            nib_count = 0;
            return 1'b0;
         end
         REC_EXT_SEG, REC_EXT_LIN: begin
            want = (rec_type == REC_EXT_SEG) ? MODE_SEGMENT : MODE_LINEAR;
            if (addr_mode == MODE_NONE) addr_mode = want;
            if (addr_mode == want) begin
               pstate = ST_EXT;
               nib_count = 0;
               rec_offset = '0;
            end else begin
               pstate = ST_TAIL;
            end
            return 1'b0;
         end
         REC_EOF, REC_START_SEG, REC_START_LIN: begin
            pstate = ST_TAIL;
            return 1'b0;
         end
         default: begin
            res.kind = KIND_UNKNOWN;
            res.addr = ADDR_W'(rec_offset);
            pstate = ST_TAIL;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic bit decode_char(input logic [7:0] c, output loader_result_type res);
      int         nv;
      logic [3:0] nib;
      res = '0;
      if (c == CHAR_COLON) begin
         pstate = ST_COUNT;
         nib_count = 0;
         rec_len = '0;
         rec_offset = '0;
         rec_type = '0;
         return 1'b0;
      end
      if (pstate == ST_IDLE) return 1'b0;
      nv = hex_nibble(c);
      if (nv < 0) begin
         pstate = ST_IDLE;
         return 1'b0;
      end
      nib = nv[3:0];
      case (pstate)
         ST_COUNT: begin
            rec_len = {rec_len[3:0], nib};
            nib_count++;
            if (nib_count >= 2) begin
               pstate = ST_OFFSET;
               nib_count = 0;
            end
         end
         ST_OFFSET: begin
            rec_offset = {rec_offset[11:0], nib};
            nib_count++;
            if (nib_count >= 4) begin
               pstate = ST_TYPE;
               nib_count = 0;
            end
         end
         ST_TYPE: begin
            rec_type = {rec_type[3:0], nib};
            nib_count++;
            if (nib_count >= 2) begin
               nib_count = 0;
               return finish_type(res);
            end
         end
         ST_DATA: begin
            if (nib_count == 0) begin
               high_nib = nib;
               nib_count = 1;
               return 1'b0;
            end
            nib_count = 0;
            res.kind = KIND_WRITE;
            res.addr = write_ptr;
            res.data = {high_nib, nib};
            write_ptr = write_ptr + 1'b1;
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) pstate = ST_TAIL;
            return 1'b1;
         end
         ST_EXT: begin
            rec_offset = {rec_offset[11:0], nib};
            nib_count++;
            if (nib_count >= 4) begin
               nib_count = 0;
               if (rec_type == REC_EXT_SEG) seg_base = rec_offset;
               else upper_base = rec_offset;
               pstate = ST_TAIL;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // checker and model update on every transfer
   always @(posedge clock) begin : monitor
      loader_result_type exp_res;
      loader_result_type new_res;
      bit                produced;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d addr %06h data %02h",
                        $time, rsp_bus.result_kind, rsp_bus.write_address, rsp_bus.write_data);
               fail_count++;
            end else begin
               exp_res = pending_results.pop_front();
               if (rsp_bus.result_kind !== exp_res.kind ||
                   rsp_bus.write_address !== exp_res.addr ||
                   rsp_bus.write_data !== exp_res.data) begin
                  $display("%0t: mismatch, expected kind %0d addr %06h data %02h, %s %0d %06h %02h",
                           $time, exp_res.kind, exp_res.addr, exp_res.data,
                           "actual kind/addr/data", rsp_bus.result_kind,
                           rsp_bus.write_address, rsp_bus.write_data);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            produced = decode_char(req_bus.char_code, new_res);
            if (produced) pending_results.push_back(new_res);
         end
         if (csr_write_en) bank_setting = csr_write_data;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n < 10) return DIGIT_LO + 8'(n);
      if ($urandom_range(0, 1) != 0) return UPPER_BASE + 8'(n);
      return LOWER_BASE + 8'(n);
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_COLON || hex_nibble(c) >= 0);
      return c;
   endfunction

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.char_code <= c;
      do @(posedge clock); while (!req_bus.ready);
      chars_sent++;
   endtask

   task automatic send_hex(input logic [15:0] v, input int digits);
      for (int i = digits - 1; i >= 0; i--) send_char(hex_digit(v[i*4 +: 4]));
   endtask

   task automatic send_record(input logic [7:0] len, input logic [15:0] offset,
                              input logic [7:0] rtype, input int data_bytes,
                              input int tail_digits);
      send_char(CHAR_COLON);
      send_hex(16'(len), 2);
      send_hex(offset, 4);
      send_hex(16'(rtype), 2);
      repeat (data_bytes) send_hex(16'($urandom_range(0, 255)), 2);
      repeat (tail_digits) send_hex(16'($urandom_range(0, 15)), 1);
   endtask

   task automatic send_ext_record(input logic [7:0] len, input logic [7:0] rtype,
                                  input logic [15:0] base_val);
      send_record(len, 16'($urandom), rtype, 0, 0);
      send_hex(base_val, 4);
      send_hex(16'($urandom_range(0, 255)), 2);
   endtask

   task automatic wait_results_done();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_bank_count(input logic [BANK_CNT_W-1:0] v);
      wait_results_done();
      repeat (HOLD_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_random_record();
      int          pick;
      logic [7:0]  len;
      logic [15:0] offset;
      logic [7:0]  rtype;
      int          tail;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         case ($urandom_range(0, 99)) inside
            [0:3]:   len = 8'd0;
            [4:96]:  len = 8'($urandom_range(1, 16));
            [97:98]: len = 8'($urandom_range(17, 64));
            default: len = 8'd255;
         endcase
         case ($urandom_range(0, 9))
            0:       offset = BANK_START;
            1:       offset = 16'($urandom_range(16'hFFF0, 16'hFFFF));
            2, 3, 4: offset = 16'($urandom_range(16'hC000, 16'hFFFF));
            default: offset = 16'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0:       tail = 0;
            1:       tail = $urandom_range(1, 5);
            default: tail = 2;
         endcase
         send_record(len, offset, REC_DATA, int'(len), tail);
      end else if (pick < 65) begin
         rtype = ($urandom_range(0, 1) != 0) ? REC_EXT_SEG : REC_EXT_LIN;
         len = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd2;
         send_ext_record(len, rtype, ($urandom_range(0, 1) != 0) ?
                         16'($urandom_range(0, 16'h1FFF)) : 16'($urandom));
      end else if (pick < 73) begin
         case ($urandom_range(0, 3))
            0:       rtype = REC_EOF;
            1:       rtype = REC_START_SEG;
            2:       rtype = REC_START_LIN;
            default: rtype = 8'($urandom_range(6, 255));
         endcase
         len = 8'($urandom_range(0, 4));
         send_record(len, 16'($urandom), rtype, int'(len), 2);
      end else if (pick < 85) begin
         send_char(CHAR_COLON);
         repeat ($urandom_range(0, 14)) send_hex(16'($urandom_range(0, 15)), 1);
         send_char(junk_char());
      end else begin
         repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_char_handling();
      send_char(8'h00);
      send_char(8'hFF);
      send_char(hex_digit(4'hA));
      send_char(CHAR_COLON);
      send_char(hex_digit(4'h0));
      send_char(8'hFF);
      send_hex(16'h12, 2);
      send_char(CHAR_COLON);
      send_hex(16'h05, 2);
      send_record(8'd1, 16'h0000, REC_DATA, 1, 2);
      send_record(8'd1, 16'hFFFF, REC_DATA, 1, 2);
   endtask

   task automatic test_record_kinds();
      send_record(8'd0, BANK_START, REC_DATA, 0, 2);
      send_record(8'd1, BANK_START, REC_DATA, 1, 2);
      send_record(8'd2, BANK_START, REC_DATA, 2, 0);
      send_record(8'd0, 16'h1234, 8'hFF, 0, 2);
      send_record(8'd0, 16'h0000, REC_EOF, 0, 2);
      send_record(8'd4, 16'h0000, REC_START_SEG, 4, 2);
      send_record(8'd4, 16'h0000, REC_START_LIN, 4, 2);
      // abandon a long record mid-data, then mid-byte
      send_record(8'hFF, 16'h0100, REC_DATA, 3, 0);
      send_char(junk_char());
      send_record(8'h02, 16'h0200, REC_DATA, 1, 1);
      send_char(CHAR_COLON);
      send_char(junk_char());
   endtask

   task automatic test_address_modes();
      logic [7:0]  first_ext;
      logic [7:0]  other_ext;
      logic [15:0] base_val;
      logic [15:0] far_offset;
      logic [7:0]  far_len;
      if ($urandom_range(0, 1) != 0) begin
         first_ext = REC_EXT_SEG;
         other_ext = REC_EXT_LIN;
         base_val = 16'h1BFF;
         far_offset = 16'h0010;
         far_len = 8'h40;
      end else begin
         first_ext = REC_EXT_LIN;
         other_ext = REC_EXT_SEG;
         base_val = 16'h0001;
         far_offset = 16'hBFF0;
         far_len = 8'h20;
      end
      send_ext_record(8'd2, first_ext, base_val);
      send_record(far_len, far_offset, REC_DATA, 2, 2);
      send_record(8'd2, 16'h0000, REC_DATA, 2, 2);
      send_ext_record(8'd2, other_ext, 16'hFFFF);
      send_record(8'd1, 16'h0003, REC_DATA, 1, 2);
      send_ext_record(8'd0, first_ext, 16'h0000);
      send_record(8'd1, 16'h0000, REC_DATA, 1, 2);
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct,
                                    input logic [BANK_CNT_W-1:0] banks, input int n_chars);
      int start_count;
      write_bank_count(banks);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start_count = chars_sent;
      while (chars_sent - start_count < n_chars / 2) send_random_record();
      // hold the sender until the block has drained
      wait_results_done();
      while (chars_sent - start_count < n_chars) begin
         send_random_record();
         if ($urandom_range(0, 199) == 0) wait_results_done();
      end
   endtask

   task automatic test_bank_advance();
      write_bank_count(7'($urandom_range(0, 127)));
      // drop each record right after its type field
      repeat (8) send_record(8'd1, BANK_START, REC_DATA, 0, 0);
      repeat (3) send_record(8'd1, BANK_START, REC_DATA, 1, 2);
   endtask

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.char_code = '0;
      rsp_bus.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 28;
      recv_idle_pct = 79;
      write_bank_count(MIN_BANKS);
      test_char_handling();
      test_record_kinds();
      test_address_modes();
      test_random_phase(28, 79, MIN_BANKS, 200);
      test_random_phase(79, 28, MAX_BANKS, 250);
      test_random_phase(0, 0, 7'h7F, 175);
      test_random_phase(0, 0, 7'h00, 175);
      test_bank_advance();

      wait_results_done();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
